// File: hw/rtl/athrd_pkg.sv
`timescale 1ns / 1ps

package athrd_pkg;

    localparam int unsigned MAX_CHUNK = 256;
    localparam int unsigned LIM_W     = 13;

    localparam logic [8:0] ACC_SAT   = 9'd511;
    localparam logic [8:0] CFG_RESET = 9'd256;
    localparam logic [3:0] HDR_LEN   = 4'd10;
    localparam logic [3:0] ERR_LEN   = 4'd9;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [2:0] K_BODY   = 3'd0;
    localparam logic [2:0] K_HEADER = 3'd1;
    localparam logic [2:0] K_ERROR  = 3'd2;
    localparam logic [2:0] K_BAD    = 3'd3;
    localparam logic [2:0] K_EMPTY  = 3'd4;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_T     = 8'h54;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [8:0] declared_length;
        logic       last;
    } t_result;

    // "+HTTPREAD:"
    function automatic logic [7:0] hdr_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h2b;
            4'd1:    c = 8'h48;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h54;
            4'd4:    c = 8'h50;
            4'd5:    c = 8'h52;
            4'd6:    c = 8'h45;
            4'd7:    c = 8'h41;
            4'd8:    c = 8'h44;
            4'd9:    c = 8'h3a;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // CR LF "ERROR" CR LF
    function automatic logic [7:0] err_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h0d;
            4'd1:    c = 8'h0a;
            4'd2:    c = 8'h45;
            4'd3:    c = 8'h52;
            4'd4:    c = 8'h52;
            4'd5:    c = 8'h4f;
            4'd6:    c = 8'h52;
            4'd7:    c = 8'h0d;
            4'd8:    c = 8'h0a;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/athrd_in_stage.sv
`timescale 1ns / 1ps

module athrd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic       o_op,
    output logic [7:0] o_byte
);
    import athrd_pkg::*;

    logic       r_valid;
    logic       r_op;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_op   <= i_op;
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_byte  = r_byte;

endmodule

// File: hw/rtl/athrd_parser.sv
`timescale 1ns / 1ps

module athrd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_op,
    input  logic [7:0]          i_byte,
    input  logic [8:0]          i_limit,
    output athrd_pkg::t_result  o_res
);
    import athrd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT, PH_SKIP, PH_DIGITS, PH_CRLF, PH_BODY, PH_DONE
    } t_phase;

    t_phase     r_phase,  n_phase;
    logic [3:0] r_hcnt,   n_hcnt;
    logic [3:0] r_ecnt,   n_ecnt;
    logic [8:0] r_acc,    n_acc;
    logic       r_digit,  n_digit;
    logic       r_cr,     n_cr;
    logic [8:0] r_rem,    n_rem;

    logic        is_digit;
    logic [3:0]  digit;
    logic [12:0] acc_next;
    logic [8:0]  rem_dec;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = 4'(i_byte - CH_ZERO);
    assign acc_next = {r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {9'd0, digit};
    assign rem_dec  = r_rem - 9'd1;

    always_comb begin
        n_phase = r_phase;
        n_hcnt  = r_hcnt;
        n_ecnt  = r_ecnt;
        n_acc   = r_acc;
        n_digit = r_digit;
        n_cr    = r_cr;
        n_rem   = r_rem;
        o_res   = '0;

        if (i_op) begin
            n_phase = PH_HUNT;
            n_hcnt  = '0;
            n_ecnt  = '0;
            n_acc   = '0;
            n_digit = 1'b0;
            n_cr    = 1'b0;
            n_rem   = '0;
        end else if (r_phase == PH_BODY) begin
            if (r_rem == '0) begin
                n_phase = PH_DONE;
            end else begin
                n_rem           = rem_dec;
                o_res.valid     = 1'b1;
                o_res.kind      = K_BODY;
                o_res.data_byte = i_byte;
                o_res.last      = (rem_dec == '0);
                if (rem_dec == '0) begin
                    n_phase = PH_DONE;
                end
            end
        end else if (r_phase == PH_HUNT || r_phase == PH_SKIP ||
                     r_phase == PH_DIGITS || r_phase == PH_CRLF) begin
            if (r_ecnt < ERR_LEN && i_byte == err_char(r_ecnt)) begin
                n_ecnt = r_ecnt + 4'd1;
            end else begin
                n_ecnt = (i_byte == CH_CR) ? 4'd1 : 4'd0;
            end

            if (n_ecnt >= ERR_LEN) begin
                n_phase     = PH_DONE;
                o_res.valid = 1'b1;
                o_res.kind  = K_ERROR;
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (r_hcnt < HDR_LEN && i_byte == hdr_char(r_hcnt)) begin
                            n_hcnt = r_hcnt + 4'd1;
                        end else begin
                            n_hcnt = (i_byte == CH_PLUS) ? 4'd1 : 4'd0;
                        end
                        if (n_hcnt >= HDR_LEN) begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        if (i_byte == CH_SPACE || i_byte == CH_D || i_byte == CH_A ||
                            i_byte == CH_T || i_byte == CH_COMMA) begin
                            n_phase = PH_SKIP;
                        end else if (!is_digit) begin
                            n_phase     = PH_DONE;
                            o_res.valid = 1'b1;
                            o_res.kind  = K_BAD;
                        end else begin
                            n_digit = 1'b1;
                            n_acc   = {5'd0, digit};
                            n_phase = PH_DIGITS;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            n_acc = (acc_next > {4'd0, ACC_SAT}) ? ACC_SAT : acc_next[8:0];
                        end else if (!r_digit || r_acc >= ACC_SAT || r_acc > i_limit) begin
                            n_phase     = PH_DONE;
                            o_res.valid = 1'b1;
                            o_res.kind  = K_BAD;
                        end else begin
                            n_cr    = (i_byte == CH_CR);
                            n_phase = PH_CRLF;
                        end
                    end
                    default: begin
                        if (r_cr && i_byte == CH_LF) begin
                            n_cr = 1'b0;
                            if (r_acc == '0) begin
                                n_phase     = PH_DONE;
                                o_res.valid = 1'b1;
                                o_res.kind  = K_EMPTY;
                            end else begin
                                n_rem                 = r_acc;
                                n_phase               = PH_BODY;
                                o_res.valid           = 1'b1;
                                o_res.kind            = K_HEADER;
                                o_res.declared_length = r_acc;
                            end
                        end else begin
                            n_cr = (i_byte == CH_CR);
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_hcnt  <= '0;
            r_ecnt  <= '0;
            r_acc   <= '0;
            r_digit <= 1'b0;
            r_cr    <= 1'b0;
            r_rem   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_ecnt  <= n_ecnt;
            r_acc   <= n_acc;
            r_digit <= n_digit;
            r_cr    <= n_cr;
            r_rem   <= n_rem;
        end
    end

endmodule

// File: hw/rtl/athrd_out_stage.sv
`timescale 1ns / 1ps

module athrd_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  athrd_pkg::t_result  i_res,
    input  logic                i_ready,
    output logic                o_free,
    output athrd_pkg::t_result  o_res
);
    import athrd_pkg::*;

    t_result r_res;

    assign o_free = !r_res.valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (o_free) begin
            r_res.valid <= i_load && i_res.valid;
        end
        if (o_free && i_load && i_res.valid) begin
            r_res.kind            <= i_res.kind;
            r_res.data_byte       <= i_res.data_byte;
            r_res.declared_length <= i_res.declared_length;
            r_res.last            <= i_res.last;
        end
    end

    assign o_res = r_res;

endmodule

// File: hw/rtl/at_http_read_response_deframer_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake                  payload
// s (in)    in   i_s_tvalid / o_s_tready    tdata: rx_byte; tuser: operation
// m (out)   out  o_m_tvalid / i_m_tready    tdata: data_byte, declared_length; tuser: kind;
//                                           tlast: last
// cfg       in   i_cfg_valid / o_cfg_ready  max_body_length
//
// One word per cycle while results are taken: input register, combinational parse logic, result register.
// A word waits in the input register until the result register is free; then its result is registered.
// Reset: synchronous, active low; limit returns to 256, parser to header hunt.
// A stalled result holds the parser; one more word waits in the input register.

module at_http_read_response_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] rx_byte
    input  logic [0:0]  i_s_tuser,    // [0] operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,    // [7:0] data_byte, [16:8] declared_length, rest zero
    output logic [2:0]  o_m_tuser,    // [2:0] kind
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);
    import athrd_pkg::*;

    logic [8:0] r_limit;
    logic       in_valid;
    logic       in_op;
    logic [7:0] in_byte;
    logic       out_free;
    logic       step;
    t_result    parse_res;
    t_result    out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= ({4'd0, i_cfg_data} > LIM_W'(MAX_CHUNK)) ?
                       9'(MAX_CHUNK) : i_cfg_data;
        end
    end

    assign step = in_valid && out_free;

    athrd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (i_s_tuser[0]),
        .i_byte  (i_s_tdata),
        .i_take  (out_free),
        .o_valid (in_valid),
        .o_op    (in_op),
        .o_byte  (in_byte)
    );

    athrd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_op    (in_op),
        .i_byte  (in_byte),
        .i_limit (r_limit),
        .o_res   (parse_res)
    );

    athrd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (parse_res),
        .i_ready (i_m_tready),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign o_m_tvalid = out_res.valid;
    assign o_m_tdata  = {7'd0, out_res.declared_length, out_res.data_byte};
    assign o_m_tuser  = out_res.kind;
    assign o_m_tlast  = out_res.last;

    a_last_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser == K_BODY)
        else $error("last set on a non-body word");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != K_BODY |-> o_m_tdata[7:0] == 8'd0)
        else $error("data byte set on a non-body word");

    a_hdr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == K_HEADER |->
            o_m_tdata[16:8] != 9'd0 && o_m_tdata[16:8] <= r_limit)
        else $error("accepted header length out of range");

    a_restart_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && in_op |=> !o_m_tvalid)
        else $error("restart produced a result");

endmodule

// File: sim/athrd_checker.sv
`timescale 1ns / 1ps

module athrd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] rx_byte
    input  logic [0:0]  i_s_tuser,    // [0] operation
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,    // [7:0] data_byte, [16:8] declared_length, rest zero
    input  logic [2:0]  i_m_tuser,    // [2:0] kind
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [8:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    import athrd_pkg::*;

    localparam logic [79:0] HDR_STR = "+HTTPREAD:";
    localparam logic [71:0] ERR_STR = "\r\nERROR\r\n";

    typedef enum logic [2:0] {
        PH_HUNT, PH_SKIP, PH_DIGITS, PH_CRLF, PH_BODY, PH_DONE
    } t_phase;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [8:0] declared_length;
        logic       last;
    } t_frame_event;

    t_phase       phase;
    logic [3:0]   hdr_cnt;
    logic [3:0]   err_cnt;
    logic [8:0]   len_acc;
    logic [8:0]   body_left;
    logic [8:0]   max_len;
    logic         digit_seen;
    logic         cr_seen;
    t_frame_event expected_events[$];
    t_frame_event want;
    t_frame_event got;
    string        want_s;
    string        got_s;
    int           fails;

    initial begin
        fails = 0;
    end

    task automatic clear_parse();
        phase      = PH_HUNT;
        hdr_cnt    = '0;
        err_cnt    = '0;
        len_acc    = '0;
        body_left  = '0;
        digit_seen = 1'b0;
        cr_seen    = 1'b0;
    endtask

    task automatic deframe_byte(input logic op, input logic [7:0] b);
        logic         is_digit;
        logic [8:0]   cap;
        int           acc_next;
        int           hi;
        int           ei;
        t_frame_event ev;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        cap      = (max_len > 9'(MAX_CHUNK)) ? 9'(MAX_CHUNK) : max_len;
        hi       = int'(hdr_cnt);
        ei       = int'(err_cnt);
        ev       = '0;
        if (op == OP_RESTART) begin
            clear_parse();
            return;
        end
        if (phase > PH_BODY) return;
        if (phase == PH_BODY) begin
            if (body_left == '0) begin
                phase = PH_DONE;
                return;
            end
            body_left    = body_left - 9'd1;
            ev.kind      = K_BODY;
            ev.data_byte = b;
            ev.last      = (body_left == '0);
            if (body_left == '0) phase = PH_DONE;
            expected_events.push_back(ev);
            return;
        end
        // error text is watched ahead of the header parse
        if (err_cnt < ERR_LEN && ei < 9 && b == ERR_STR[71 - 8 * ei -: 8]) begin
            err_cnt = err_cnt + 4'd1;
        end else begin
            err_cnt = (b == CH_CR) ? 4'd1 : 4'd0;
        end
        if (err_cnt >= ERR_LEN) begin
            phase   = PH_DONE;
            ev.kind = K_ERROR;
            expected_events.push_back(ev);
            return;
        end
        case (phase)
            PH_HUNT: begin
                if (hdr_cnt < HDR_LEN && hi < 10 &&
                    b == HDR_STR[79 - 8 * hi -: 8]) begin
                    hdr_cnt = hdr_cnt + 4'd1;
                end else begin
                    hdr_cnt = (b == CH_PLUS) ? 4'd1 : 4'd0;
                end
                if (hdr_cnt >= HDR_LEN) phase = PH_SKIP;
            end
            PH_SKIP: begin
                if (b == CH_SPACE || b == CH_D || b == CH_A ||
                    b == CH_T || b == CH_COMMA) begin
                end else if (!is_digit) begin
                    phase   = PH_DONE;
                    ev.kind = K_BAD;
                    expected_events.push_back(ev);
                end else begin
                    digit_seen = 1'b1;
                    len_acc    = 9'(b - CH_ZERO);
                    phase      = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    acc_next = int'(len_acc) * 10 + int'(b - CH_ZERO);
                    len_acc  = (acc_next > int'(ACC_SAT)) ? ACC_SAT : 9'(acc_next);
                end else if (!digit_seen || len_acc >= ACC_SAT || len_acc > cap) begin
                    phase   = PH_DONE;
                    ev.kind = K_BAD;
                    expected_events.push_back(ev);
                end else begin
                    cr_seen = (b == CH_CR);
                    phase   = PH_CRLF;
                end
            end
            default: begin
                if (cr_seen && b == CH_LF) begin
                    cr_seen = 1'b0;
                    if (len_acc == '0) begin
                        phase   = PH_DONE;
                        ev.kind = K_EMPTY;
                    end else begin
                        body_left          = len_acc;
                        phase              = PH_BODY;
                        ev.kind            = K_HEADER;
                        ev.declared_length = len_acc;
                    end
                    expected_events.push_back(ev);
                end else begin
                    cr_seen = (b == CH_CR);
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            max_len = CFG_RESET;
            expected_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) max_len = i_cfg_data;
            if (i_m_tvalid && i_m_tready) begin
                got.kind            = i_m_tuser;
                got.data_byte       = i_m_tdata[7:0];
                got.declared_length = i_m_tdata[16:8];
                got.last            = i_m_tlast;
                got_s = $sformatf("kind %0d data %02h len %0d last %0b",
                                  got.kind, got.data_byte, got.declared_length, got.last);
                if (expected_events.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected word: expected none, got %s", $time, got_s);
                end else begin
                    want = expected_events.pop_front();
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.declared_length !== want.declared_length ||
                        got.last !== want.last || i_m_tdata[23:17] !== '0) begin
                        fails++;
                        want_s = $sformatf("kind %0d data %02h len %0d last %0b",
                                           want.kind, want.data_byte,
                                           want.declared_length, want.last);
                        $display("%0t: mismatch: expected %s, got %s pad %02h",
                                 $time, want_s, got_s, i_m_tdata[23:17]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) deframe_byte(i_s_tuser[0], i_s_tdata);
        end
        o_pending    <= expected_events.size();
        o_fail_count <= fails;
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    import athrd_pkg::*;

    localparam int IDLE_LIMIT      = 1000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int NUM_PHASES      = 5;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data  = '0;

    int          fail_count;
    int          pending;
    logic        idle_en   = 1'b1;
    int          ready_hold = 0;
    int          quiet     = 0;
    int          words_sent = 0;
    logic [8:0]  cur_limit = CFG_RESET;

    always #2 clk = ~clk;

    at_http_read_response_deframer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    athrd_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver back-pressure in random bursts
    always @(posedge clk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            m_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            ready_hold = $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [7:0] noise_byte();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = CH_CR;
            1:       c = CH_LF;
            2:       c = CH_PLUS;
            3:       c = 8'h45;
            4:       c = 8'h52;
            default: c = 8'($urandom);
        endcase
        return c;
    endfunction

    task automatic send_word(input logic op, input logic [7:0] b);
        int gap;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_word(OP_BYTE, t[i]);
    endtask

    // stop sending, wait for every expected word, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [8:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_limit = v;
    endtask

    // one response: optional restart, noise, then an ERROR reply or header, filler, length, terminator, body, tail
    task automatic send_frame(input int forced_len);
        int    lim;
        int    v;
        int    nbody;
        int    abort_at;
        string len_txt;
        lim = (cur_limit > 9'(MAX_CHUNK)) ? MAX_CHUNK : int'(cur_limit);
        v   = -1;
        if ($urandom_range(0, 9) != 0) send_word(OP_RESTART, 8'($urandom));
        repeat ($urandom_range(0, 4)) send_word(OP_BYTE, noise_byte());
        if ($urandom_range(0, 11) == 0) begin
            send_text("\r\nERROR\r\n");
            send_text("OK\r\n");
            return;
        end
        if ($urandom_range(0, 14) == 0) send_text("+HTTPRAED:");
        else send_text("+HTTPREAD:");
        case ($urandom_range(0, 3))
            0: ;
            1: send_text(" ");
            2: send_text(" DATA,");
            default: begin
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(0, 4))
                        0: send_word(OP_BYTE, CH_SPACE);
                        1: send_word(OP_BYTE, CH_D);
                        2: send_word(OP_BYTE, CH_A);
                        3: send_word(OP_BYTE, CH_T);
                        default: send_word(OP_BYTE, CH_COMMA);
                    endcase
                end
            end
        endcase
        if (forced_len >= 0) begin
            v = forced_len;
        end else begin
            case ($urandom_range(0, 39))
                0, 1: v = -1;
                2, 3: v = lim + $urandom_range(1, 30);
                4:    v = $urandom_range(0, 1) ? 511 : $urandom_range(512, 99999);
                5:    v = lim;
                6, 7: v = 0;
                default: v = $urandom_range(1, (lim < 12) ? lim : 12);
            endcase
        end
        if (v >= 0) begin
            len_txt = $sformatf("%0d", v);
            if ($urandom_range(0, 7) == 0) len_txt = {"00", len_txt};
            send_text(len_txt);
        end else if ($urandom_range(0, 1) == 0) begin
            send_word(OP_BYTE, 8'h78);
        end
        case ($urandom_range(0, 9))
            0: send_text(" \r\n");
            1: send_text("\r\r\n");
            2: send_text("\rx\r\n");
            default: send_text("\r\n");
        endcase
        nbody    = (v >= 0 && v <= lim) ? v : $urandom_range(0, 3);
        abort_at = ($urandom_range(0, 19) == 0 && nbody > 1) ?
                   $urandom_range(1, nbody - 1) : -1;
        for (int i = 0; i < nbody; i++) begin
            if (i == abort_at) begin
                send_word(OP_RESTART, 8'($urandom));
                break;
            end
            send_word(OP_BYTE, noise_byte());
        end
        repeat ($urandom_range(0, 2)) send_word(OP_BYTE, noise_byte());
    endtask

    initial begin
        int         start;
        logic [8:0] v;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset limit
        send_text("+HTTPREAD: 3\r\n");
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hff);
        send_word(OP_BYTE, CH_CR);
        send_word(OP_BYTE, 8'h78);
        send_word(OP_RESTART, 8'hff);
        send_text("+HTTPREAD: DATA,0\r\n");
        send_word(OP_RESTART, 8'h00);
        send_text("+HTTPREAD:99999\r\n");
        send_word(OP_RESTART, 8'h5a);
        send_text("+HTTPREAD:257\r");
        send_word(OP_RESTART, 8'ha5);
        send_text("+HTTPREAD:,\r");
        send_word(OP_RESTART, 8'h0f);
        send_text("+HTTP\r\nERROR\r\n");
        send_word(OP_RESTART, 8'hf0);
        send_text("++HTTPREAD:1\r\n");
        send_word(OP_BYTE, 8'h80);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       v = 9'd1;
                1:       v = 9'd256;
                2:       v = 9'($urandom_range(2, 40));
                3:       v = 9'($urandom_range(41, 255));
                default: v = 9'($urandom_range(1, 256));
            endcase
            write_limit(v);
            if (ph == NUM_PHASES - 1) idle_en <= 1'b0;
            start = words_sent;
            if (v == 9'd256) send_frame(256);
            while (words_sent - start < ITEMS_PER_PHASE) begin
                if (ph != NUM_PHASES - 1) idle_en <= ($urandom_range(0, 3) != 0);
                send_frame(-1);
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
